/* hw/rtl/frame_sync_period_tracker_assert.svh */
// assertion macros for the frame sync period tracker checker
`ifndef FRAME_SYNC_PERIOD_TRACKER_ASSERT_SVH
`define FRAME_SYNC_PERIOD_TRACKER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FSPT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FSPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fspt_pkg.sv */
package fspt_pkg;

	localparam int unsigned TICK_W  = 32;
	localparam int unsigned FRAME_W = 16;
	localparam int unsigned LOSS_W  = 8;
	localparam int unsigned LIMIT_W = TICK_W + LOSS_W;

	localparam logic [LOSS_W-1:0] LOSS_FRAMES_RESET = LOSS_W'(3);

	// request kinds
	localparam logic REQ_CAPTURE = 1'b0;
	localparam logic REQ_POLL    = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [TICK_W-1:0] tick_value;
	} fspt_in_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_count;
		logic [TICK_W-1:0]  last_capture;
		logic [TICK_W-1:0]  period_estimate;
		logic               in_sync;
		logic               sync_dropped;
	} fspt_out_t;

endpackage

/* hw/rtl/frame_sync_period_tracker.sv */
// Frame sync period tracker. Each input item is either a sync-edge capture
// (req_type 0, tick_value = capture timestamp) or a poll (req_type 1,
// tick_value = current time), and each item yields exactly one snapshot item
// holding the frame count, last capture time, smoothed period, sync status
// and a flag set when that poll has just declared sync lost. The first
// interval after reset or loss is taken as the period; later ones are
// blended in with quarter weight. Sync is dropped by a poll once the elapsed
// time reaches loss_frames times the period, compared at full 40-bit width.
// Items are processed one per clock cycle while the output is taken: an item
// goes from the input register through the update logic into the output
// register, and a new item can be accepted in every cycle while the output is
// being taken. loss_frames resets to 3 and is to be written through
// cfg_we/cfg_wdata only while no item is in flight; the block does not enforce it.
module frame_sync_period_tracker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [fspt_pkg::LOSS_W-1:0]           cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  fspt_pkg::fspt_in_t                    in_item,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output fspt_pkg::fspt_out_t                   out_item
);

	fspt_pkg::fspt_in_t              item_s1;
	logic                            valid_s1;
	fspt_pkg::fspt_out_t             out_item_q;
	logic                            out_valid_q;

	logic [fspt_pkg::LOSS_W-1:0]     loss_q;
	logic [fspt_pkg::FRAME_W-1:0]    frame_q;
	logic [fspt_pkg::TICK_W-1:0]     prev_q;
	logic [fspt_pkg::TICK_W-1:0]     period_q;
	logic                            locked_q;
	logic                            base_q;

	logic                            advance;
	logic [fspt_pkg::TICK_W-1:0]     interval;
	logic [fspt_pkg::TICK_W-1:0]     ema;
	logic [fspt_pkg::LIMIT_W-1:0]    limit;
	logic [fspt_pkg::FRAME_W-1:0]    frame_d;
	logic [fspt_pkg::TICK_W-1:0]     prev_d;
	logic [fspt_pkg::TICK_W-1:0]     period_d;
	logic                            locked_d;
	logic                            base_d;
	logic                            dropped_d;

	// handshake: stage 1 moves on when the output register is free or drained
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// interval, smoothed blend and loss threshold
	assign interval = item_s1.tick_value - prev_q;
	assign ema      = (period_q - (period_q >> 2)) + (interval >> 2);
	assign limit    = fspt_pkg::LIMIT_W'(loss_q) * fspt_pkg::LIMIT_W'(period_q);

	// next state for the item in stage 1
	always_comb begin
		frame_d   = frame_q;
		prev_d    = prev_q;
		period_d  = period_q;
		locked_d  = locked_q;
		base_d    = base_q;
		dropped_d = 1'b0;
		case (item_s1.req_type)
			fspt_pkg::REQ_CAPTURE: begin
				frame_d = frame_q + fspt_pkg::FRAME_W'(1);
				if (base_q) begin
					period_d = locked_q ? ema : interval;
					locked_d = 1'b1;
				end
				base_d = 1'b1;
				prev_d = item_s1.tick_value;
			end
			fspt_pkg::REQ_POLL: begin
				if (locked_q && (period_q != '0)
						&& (fspt_pkg::LIMIT_W'(interval) >= limit)) begin
					locked_d  = 1'b0;
					base_d    = 1'b0;
					dropped_d = 1'b1;
				end
			end
			default: begin
				dropped_d = 1'b0;
			end
		endcase
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.frame_count     <= frame_d;
			out_item_q.last_capture    <= prev_d;
			out_item_q.period_estimate <= period_d;
			out_item_q.in_sync         <= locked_d;
			out_item_q.sync_dropped    <= dropped_d;
		end
	end

	// tracker state and loss threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_q   <= fspt_pkg::LOSS_FRAMES_RESET;
			frame_q  <= '0;
			prev_q   <= '0;
			period_q <= '0;
			locked_q <= 1'b0;
			base_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				loss_q <= cfg_wdata;
			end
			if (advance) begin
				frame_q  <= frame_d;
				prev_q   <= prev_d;
				period_q <= period_d;
				locked_q <= locked_d;
				base_q   <= base_d;
			end
		end
	end

endmodule

/* hw/rtl/fspt_checker.sv */
`include "frame_sync_period_tracker_assert.svh"

module fspt_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  fspt_pkg::fspt_in_t            in_item,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  fspt_pkg::fspt_out_t           out_item
);

	logic out_take;

	assign out_take = out_valid && out_ready;

	// a waiting input item holds until taken
	`FSPT_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_item), "input item changed while waiting")

	// a stalled result item holds
	`FSPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result item changed while stalled")

	// with the output register empty the input side never stalls
	`FSPT_ASSERT_SAME(a_no_idle_stall, !out_valid, in_ready, "input stalled while output register empty")

	// a drop leaves the tracker out of sync and only happens with a nonzero period
	`FSPT_ASSERT_SAME(a_drop_state, out_take && out_item.sync_dropped, !out_item.in_sync && (out_item.period_estimate != '0), "sync drop reported with inconsistent state")

endmodule

bind frame_sync_period_tracker fspt_checker u_fspt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

/* tb/sv/tb_frame_sync_period_tracker.sv */
`timescale 1ns / 100ps

import fspt_pkg::*;

// predicts every snapshot of the tracker and checks the observed ones in order
class sync_snapshot_model;
	logic [LOSS_W-1:0]  loss_frames;
	logic [FRAME_W-1:0] frames;
	logic [TICK_W-1:0]  prev_capture;
	logic [TICK_W-1:0]  period;
	logic               locked;
	logic               baseline;
	fspt_out_t          snapshot_q[$];
	int                 mismatch_count;
	int                 captures;
	int                 polls;
	int                 drops;

	function new();
		loss_frames    = LOSS_FRAMES_RESET;
		frames         = '0;
		prev_capture   = '0;
		period         = '0;
		locked         = 1'b0;
		baseline       = 1'b0;
		mismatch_count = 0;
		captures       = 0;
		polls          = 0;
		drops          = 0;
	endfunction

	function void report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endfunction

	// advance the predicted state by one accepted item and queue its snapshot
	function void note_item(fspt_in_t it);
		logic [TICK_W-1:0]  interval;
		logic [LIMIT_W-1:0] limit;
		fspt_out_t          snap;
		snap.sync_dropped = 1'b0;
		interval = it.tick_value - prev_capture;
		if (it.req_type == REQ_CAPTURE) begin
			captures++;
			frames = frames + 1'b1;
			if (baseline) begin
				if (!locked)
					period = interval;
				else
					period = (period - (period >> 2)) + (interval >> 2);
				locked = 1'b1;
			end
			baseline     = 1'b1;
			prev_capture = it.tick_value;
		end else begin
			polls++;
			// threshold at full width, never wrapped
			limit = LIMIT_W'(loss_frames) * LIMIT_W'(period);
			if (locked && period != '0 && LIMIT_W'(interval) >= limit) begin
				locked            = 1'b0;
				baseline          = 1'b0;
				snap.sync_dropped = 1'b1;
				drops++;
			end
		end
		snap.frame_count     = frames;
		snap.last_capture    = prev_capture;
		snap.period_estimate = period;
		snap.in_sync         = locked;
		snapshot_q.push_back(snap);
	endfunction

	// compare one observed snapshot with the oldest prediction
	function void check_snapshot(fspt_out_t got);
		fspt_out_t want;
		if (snapshot_q.size() == 0) begin
			report($sformatf("snapshot %h with nothing outstanding", got));
			return;
		end
		want = snapshot_q.pop_front();
		if (got.frame_count !== want.frame_count)
			report($sformatf("frame_count %h, expected %h", got.frame_count, want.frame_count));
		if (got.last_capture !== want.last_capture)
			report($sformatf("last_capture %h, expected %h", got.last_capture,
				want.last_capture));
		if (got.period_estimate !== want.period_estimate)
			report($sformatf("period_estimate %h, expected %h", got.period_estimate,
				want.period_estimate));
		if (got.in_sync !== want.in_sync)
			report($sformatf("in_sync %b, expected %b", got.in_sync, want.in_sync));
		if (got.sync_dropped !== want.sync_dropped)
			report($sformatf("sync_dropped %b, expected %b", got.sync_dropped,
				want.sync_dropped));
	endfunction
endclass

module tb_frame_sync_period_tracker;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [LOSS_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	fspt_in_t          in_item;
	logic              out_valid;
	logic              out_ready;
	fspt_out_t         out_item;

	sync_snapshot_model model = new();
	bit                 steady;
	logic [TICK_W-1:0]  nominal;
	string              settings_list = " 3";

	// reset value of loss_frames: wrap, zero period, full-width threshold
	fspt_in_t directed_items[19] = '{
		'{REQ_POLL,    32'h1234_5678},
		'{REQ_CAPTURE, 32'hFFFF_FFF0},
		'{REQ_POLL,    32'hFFFF_FFFF},
		'{REQ_CAPTURE, 32'h0000_0010},
		'{REQ_CAPTURE, 32'h0000_0030},
		'{REQ_POLL,    32'h0000_008F},
		'{REQ_POLL,    32'h0000_0090},
		'{REQ_POLL,    32'h0000_0090},
		'{REQ_CAPTURE, 32'hA5A5_A5A5},
		'{REQ_CAPTURE, 32'hA5A5_A5A5},
		'{REQ_POLL,    32'hA5A5_A5A4},
		'{REQ_CAPTURE, 32'hA5A5_A5A4},
		'{REQ_POLL,    32'hA5A5_A5A3},
		'{REQ_CAPTURE, 32'h0000_0000},
		'{REQ_CAPTURE, 32'hFFFF_FFFF},
		'{REQ_POLL,    32'hFFFF_FFFE},
		'{REQ_CAPTURE, 32'h5A5A_5A5A},
		'{REQ_POLL,    32'hFFFF_FFFF},
		'{REQ_CAPTURE, 32'h0000_0000}
	};

	frame_sync_period_tracker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// present one item after a random gap and hold it until taken
	task automatic send_item(fspt_in_t it);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		model.note_item(it);
	endtask

	// write loss_frames once every outstanding snapshot has come back
	task automatic set_loss(logic [LOSS_W-1:0] v);
		in_valid <= 1'b0;
		while (model.snapshot_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.loss_frames = v;
		settings_list = {settings_list, $sformatf(" %0d", v)};
	endtask

	// mostly periodic captures and polls aimed at the loss threshold, some noise
	function automatic fspt_in_t next_tracker_item();
		int unsigned        r;
		logic [TICK_W-1:0]  jitter_span;
		logic [LIMIT_W-1:0] limit;
		fspt_in_t           it;
		r = $urandom_range(0, 99);
		it.req_type = REQ_POLL;
		limit = LIMIT_W'(model.loss_frames) * LIMIT_W'(model.period);
		if (r < 55) begin
			it.req_type   = REQ_CAPTURE;
			jitter_span   = (nominal >> 3) + 1;
			it.tick_value = model.prev_capture + nominal - (jitter_span >> 1)
				+ $urandom_range(0, jitter_span);
		end else if (r < 85) begin
			if (model.locked && limit >= 3 && limit < 40'h01_0000_0000)
				it.tick_value = model.prev_capture + limit[TICK_W-1:0] - 2
					+ $urandom_range(0, 3);
			else
				it.tick_value = model.prev_capture + TICK_W'($urandom_range(0, nominal)) * 3;
		end else if (r < 92) begin
			it.tick_value = model.prev_capture + $urandom();
		end else begin
			it.req_type   = ($urandom_range(0, 1) == 0) ? REQ_CAPTURE : REQ_POLL;
			it.tick_value = $urandom();
		end
		return it;
	endfunction

	// result side: random stall before each item, then take it
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = steady ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			model.check_snapshot(out_item);
		end
	end

	// stimulus and end of run
	initial begin
		logic [LOSS_W-1:0] loss;
		int                drain;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_item   = '0;
		steady    = 1'b0;
		nominal   = 32'd100;
		arst_n    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_items[i])
			send_item(directed_items[i]);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: loss = 8'd1;
				1: loss = 8'd255;
				2: loss = 8'd0;
				4: loss = 8'd2;
				6: loss = LOSS_FRAMES_RESET;
				default: loss = LOSS_W'($urandom_range(1, 254));
			endcase
			set_loss(loss);
			// the widest setting gets periods whose threshold straddles 32 bits
			case (p == 1 ? 2 : $urandom_range(0, 3))
				0: nominal = $urandom_range(1, 64);
				1: nominal = $urandom_range(65, 100000);
				2: nominal = $urandom_range(32'h0010_0000, 32'h0400_0000);
				default: nominal = $urandom() | 32'h4000_0000;
			endcase
			steady = (p == 3) || (p == 6);
			repeat (110) send_item(next_tracker_item());
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		drain = 0;
		while (model.snapshot_q.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (model.snapshot_q.size() != 0)
			model.report($sformatf("%0d snapshots never arrived", model.snapshot_q.size()));

		$display("checked %0d captures and %0d polls, %0d of which dropped sync",
			model.captures, model.polls, model.drops);
		$display("loss_frames settings used:%s", settings_list);
		if (model.mismatch_count == 0) begin
			$display("[frame_sync_period_tracker] OK");
		end else begin
			$display("[frame_sync_period_tracker] ERROR");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#2_000_000;
		$display("[frame_sync_period_tracker] ERROR");
		$finish;
	end

endmodule
